// ----- hdl/csp_pkg.sv -----
// Shared widths, constants, codes and payload types of the calendar span phase block.
// Used by every file in hdl/; depends on nothing.
`default_nettype none

package csp_pkg;

  // Field widths of the time stamp
  localparam int SEC_W  = 6;
  localparam int MIN_W  = 6;
  localparam int HOUR_W = 5;
  localparam int DOM_W  = 5;
  localparam int DOW_W  = 3;
  localparam int DIM_W  = 5;

  // Configuration port
  localparam int MODE_W = 2;
  localparam int CNT_W  = 16;
  localparam int IDX_W  = 2;
  localparam int CFG_W  = 16;

  // Elapsed seconds and span length both stay below 2^22 for any field pattern
  localparam int E_W    = 22;
  localparam int SPAN_W = 22;
  localparam int PROD_W = E_W + CNT_W;

  // Phase scaling: full scale is a power of two
  localparam int FS_LOG2 = 16;
  localparam int FRAC_W  = FS_LOG2 + 1;
  localparam int PHASE_W = FRAC_W;
  localparam logic [PHASE_W-1:0] FULL_SCALE = PHASE_W'(1 << FS_LOG2);

  // Cell counts of the divider chain
  localparam int N_INT  = PROD_W;
  localparam int N_FRAC = FRAC_W;

  // Seconds constants
  localparam logic [E_W-1:0]    SECS_MIN    = E_W'(60);
  localparam logic [E_W-1:0]    SECS_HOUR   = E_W'(3600);
  localparam logic [E_W-1:0]    SECS_DAY    = E_W'(86400);
  localparam logic [SPAN_W-1:0] SPAN_HOUR   = SPAN_W'(3600);
  localparam logic [SPAN_W-1:0] SPAN_DAY    = SPAN_W'(86400);
  localparam logic [SPAN_W-1:0] SPAN_WEEK   = SPAN_W'(7 * 86400);
  localparam logic [SPAN_W-1:0] SPAN_ONE    = SPAN_W'(1);

  typedef enum logic [MODE_W-1:0] {
    MODE_HOUR  = 2'd0,
    MODE_DAY   = 2'd1,
    MODE_WEEK  = 2'd2,
    MODE_MONTH = 2'd3
  } span_mode_e;

  typedef enum logic [IDX_W-1:0] {
    REG_SPAN_MODE   = 2'd0,
    REG_SLICE_COUNT = 2'd1,
    REG_WRAP_ENABLE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    span_mode_e       span_mode;
    logic [CNT_W-1:0] slice_count;
    logic             wrap_enable;
  } cfg_t;

  typedef struct packed {
    logic [E_W-1:0]    elapsed;
    logic [SPAN_W-1:0] span;
  } span_t;

  // Payload travelling along the divider chain
  typedef struct packed {
    logic [SPAN_W-1:0] rem;   // partial remainder, always below span
    logic [SPAN_W-1:0] span;  // divisor
    logic [PROD_W-1:0] num;   // dividend bits still to shift in, MSB first
    logic [FRAC_W-1:0] quo;   // quotient bits, newest in the LSB
    logic              full;  // reversed phase covers the whole slice
  } div_t;

endpackage

`default_nettype wire

// ----- hdl/csp_if.sv -----
// Valid/ready channel interfaces for time stamp requests and phase results.
// Depends on csp_pkg.
`default_nettype none

interface csp_in_if;
  logic                      valid;
  logic                      ready;
  logic [csp_pkg::SEC_W-1:0]  second_of_minute;
  logic [csp_pkg::MIN_W-1:0]  minute_of_hour;
  logic [csp_pkg::HOUR_W-1:0] hour_of_day;
  logic [csp_pkg::DOM_W-1:0]  day_of_month;
  logic [csp_pkg::DOW_W-1:0]  day_of_week;
  logic [csp_pkg::DIM_W-1:0]  days_in_month;

  modport source (
    output valid, second_of_minute, minute_of_hour, hour_of_day,
           day_of_month, day_of_week, days_in_month,
    input  ready
  );
  modport sink (
    input  valid, second_of_minute, minute_of_hour, hour_of_day,
           day_of_month, day_of_week, days_in_month,
    output ready
  );
endinterface

interface csp_out_if;
  logic                        valid;
  logic                        ready;
  logic [csp_pkg::PHASE_W-1:0] phase;

  modport source (output valid, phase, input ready);
  modport sink   (input valid, phase, output ready);
endinterface

`default_nettype wire

// ----- hdl/csp_front.sv -----
// Front end: elapsed seconds and span length, then the scaling by the slice count.
// Two pipeline stages; depends on csp_pkg and csp_if.
`default_nettype none

module csp_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  csp_in_if.sink                         in_i,
  input  wire csp_pkg::span_mode_e       span_mode_i,
  input  wire logic [csp_pkg::CNT_W-1:0] slice_count_i,
  output logic                           valid_o,
  input  wire logic                      ready_i,
  output csp_pkg::div_t                  data_o
);

  logic            s1_valid_q, s2_valid_q;
  logic            s1_ready, s2_ready;
  csp_pkg::span_t  s1_d, s1_q;
  csp_pkg::div_t   s2_d, s2_q;
  logic [csp_pkg::E_W-1:0]    in_day;
  logic [csp_pkg::E_W-1:0]    in_hour;
  logic [csp_pkg::SPAN_W-1:0] month_span;

  assign s2_ready   = !s2_valid_q || ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_i.ready = s1_ready;

  // Stage 1: seconds into the span and span length
  always_comb begin
    in_hour = csp_pkg::E_W'(in_i.minute_of_hour) * csp_pkg::SECS_MIN
            + csp_pkg::E_W'(in_i.second_of_minute);
    in_day  = csp_pkg::E_W'(in_i.hour_of_day) * csp_pkg::SECS_HOUR + in_hour;
    month_span = csp_pkg::SPAN_W'(in_i.days_in_month) * csp_pkg::SPAN_DAY;
    unique case (span_mode_i)
      csp_pkg::MODE_HOUR: begin
        s1_d.elapsed = in_hour;
        s1_d.span    = csp_pkg::SPAN_HOUR;
      end
      csp_pkg::MODE_DAY: begin
        s1_d.elapsed = in_day;
        s1_d.span    = csp_pkg::SPAN_DAY;
      end
      csp_pkg::MODE_WEEK: begin
        s1_d.elapsed = csp_pkg::E_W'(in_i.day_of_week) * csp_pkg::SECS_DAY + in_day;
        s1_d.span    = csp_pkg::SPAN_WEEK;
      end
      default: begin
        s1_d.elapsed = csp_pkg::E_W'(in_i.day_of_month) * csp_pkg::SECS_DAY + in_day;
        // empty month counts as a one-second span
        s1_d.span    = (in_i.days_in_month == '0) ? csp_pkg::SPAN_ONE : month_span;
      end
    endcase
  end

  // Stage 2: scale by the slice count, seed the divider
  always_comb begin
    s2_d.num  = csp_pkg::PROD_W'(s1_q.elapsed) * csp_pkg::PROD_W'(slice_count_i);
    s2_d.span = s1_q.span;
    s2_d.rem  = '0;
    s2_d.quo  = '0;
    s2_d.full = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_i.valid;
      if (s2_ready) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_i.valid) s1_q <= s1_d;
    if (s2_ready && s1_valid_q) s2_q <= s2_d;
  end

  assign valid_o = s2_valid_q;
  assign data_o  = s2_q;

  // Checks
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> s1_valid_q)
    else $error("accepted request did not reach stage 1");
  a_span_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (s2_q.span != '0))
    else $error("zero span seeded into divider");

endmodule

`default_nettype wire

// ----- hdl/csp_div_cell.sv -----
// One cell of the restoring divider chain: shifts in one dividend bit and
// produces one quotient bit per item. Depends on csp_pkg.
`default_nettype none

module csp_div_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire csp_pkg::div_t data_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output csp_pkg::div_t      data_o
);

  logic                        valid_q;
  csp_pkg::div_t               data_d, data_q;
  logic [csp_pkg::SPAN_W:0]    trial;
  logic [csp_pkg::SPAN_W:0]    diff;
  logic                        fits;

  assign ready_o = !valid_q || ready_i;

  // Compare and subtract
  always_comb begin
    trial       = {data_i.rem, data_i.num[csp_pkg::PROD_W-1]};
    diff        = trial - {1'b0, data_i.span};
    fits        = trial >= {1'b0, data_i.span};
    data_d      = data_i;
    data_d.rem  = fits ? diff[csp_pkg::SPAN_W-1:0] : trial[csp_pkg::SPAN_W-1:0];
    data_d.num  = {data_i.num[csp_pkg::PROD_W-2:0], 1'b0};
    data_d.quo  = {data_i.quo[csp_pkg::FRAC_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  a_rem_below_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (data_q.rem < data_q.span))
    else $error("partial remainder reached the divisor");

endmodule

`default_nettype wire

// ----- hdl/csp_wrap.sv -----
// Wrap stage between the integer and fraction cells: reverses the remainder
// in odd slices when wrap is enabled. Depends on csp_pkg.
`default_nettype none

module csp_wrap (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wrap_enable_i,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire csp_pkg::div_t data_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output csp_pkg::div_t      data_o
);

  logic          valid_q;
  csp_pkg::div_t data_d, data_q;
  logic          odd_slice;

  assign ready_o = !valid_q || ready_i;

  // Slice parity is the last integer quotient bit
  always_comb begin
    odd_slice = wrap_enable_i && data_i.quo[0];
    data_d    = data_i;
    data_d.full = 1'b0;
    if (odd_slice) begin
      if (data_i.rem == '0) begin
        // reversed zero covers the whole slice
        data_d.full = 1'b1;
      end else begin
        data_d.rem = data_i.span - data_i.rem;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  a_full_rem_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && data_q.full) |-> (data_q.rem == '0))
    else $error("full flag with nonzero remainder");
  a_num_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (data_q.num == '0))
    else $error("dividend bits left after the integer cells");

endmodule

`default_nettype wire

// ----- hdl/calendar_span_phase_top.sv -----
// Top level of the calendar span phase block: configuration registers, the
// divider cell chain and the output register. Depends on csp_pkg, csp_if,
// csp_front, csp_div_cell and csp_wrap.
//
// Usage:
//   in_i carries time stamp requests (valid/ready), out_o carries one phase
//   result per request in request order. cfg_we_i/cfg_idx_i/cfg_wdata_i write
//   span mode (0), slice count (1) and wrap enable (2); other indexes are
//   ignored. Write configuration only while no request is in flight.
//   59 register stages: two front stages (span decode, 22x16 multiply),
//   38 integer divider cells, the wrap stage, 17 fraction cells and the output
//   register. One divider cell per quotient bit, so a new request is accepted
//   every cycle unless a stalled receiver has filled the chain.
//   Each stage carries its own valid bit; when the receiver stalls, stages
//   close up behind the held result and in_i.ready stays high while any
//   stage is empty.
//   Reset clears all valid bits and loads span mode hour, slice count 1 and
//   wrap off. There is no clearing pass.
`default_nettype none

module calendar_span_phase_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  csp_in_if.sink                         in_i,
  csp_out_if.source                      out_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [csp_pkg::IDX_W-1:0] cfg_idx_i,
  input  wire logic [csp_pkg::CFG_W-1:0] cfg_wdata_i
);

  csp_pkg::cfg_t cfg_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.span_mode   <= csp_pkg::MODE_HOUR;
      cfg_q.slice_count <= csp_pkg::CNT_W'(1);
      cfg_q.wrap_enable <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (csp_pkg::cfg_idx_e'(cfg_idx_i))
        csp_pkg::REG_SPAN_MODE:
          cfg_q.span_mode <= csp_pkg::span_mode_e'(cfg_wdata_i[csp_pkg::MODE_W-1:0]);
        csp_pkg::REG_SLICE_COUNT:
          cfg_q.slice_count <= cfg_wdata_i[csp_pkg::CNT_W-1:0];
        csp_pkg::REG_WRAP_ENABLE:
          cfg_q.wrap_enable <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Integer part of the chain
  logic          int_valid [csp_pkg::N_INT+1];
  logic          int_ready [csp_pkg::N_INT+1];
  csp_pkg::div_t int_data  [csp_pkg::N_INT+1];

  csp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .span_mode_i   (cfg_q.span_mode),
    .slice_count_i (cfg_q.slice_count),
    .valid_o       (int_valid[0]),
    .ready_i       (int_ready[0]),
    .data_o        (int_data[0])
  );

  for (genvar g = 0; g < csp_pkg::N_INT; g++) begin : g_int
    csp_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (int_valid[g]),
      .ready_o (int_ready[g]),
      .data_i  (int_data[g]),
      .valid_o (int_valid[g+1]),
      .ready_i (int_ready[g+1]),
      .data_o  (int_data[g+1])
    );
  end

  // Fraction part of the chain
  logic          frac_valid [csp_pkg::N_FRAC+1];
  logic          frac_ready [csp_pkg::N_FRAC+1];
  csp_pkg::div_t frac_data  [csp_pkg::N_FRAC+1];

  csp_wrap u_wrap (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wrap_enable_i (cfg_q.wrap_enable),
    .valid_i       (int_valid[csp_pkg::N_INT]),
    .ready_o       (int_ready[csp_pkg::N_INT]),
    .data_i        (int_data[csp_pkg::N_INT]),
    .valid_o       (frac_valid[0]),
    .ready_i       (frac_ready[0]),
    .data_o        (frac_data[0])
  );

  for (genvar g = 0; g < csp_pkg::N_FRAC; g++) begin : g_frac
    csp_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (frac_valid[g]),
      .ready_o (frac_ready[g]),
      .data_i  (frac_data[g]),
      .valid_o (frac_valid[g+1]),
      .ready_i (frac_ready[g+1]),
      .data_o  (frac_data[g+1])
    );
  end

  // Round half up: (q + 1) >> 1 of the extra-bit quotient
  logic                        out_valid_q;
  logic [csp_pkg::PHASE_W-1:0] phase_d, phase_q;
  logic [csp_pkg::FRAC_W:0]    quo_inc;
  logic                        out_ready;

  assign out_ready = !out_valid_q || out_o.ready;
  assign frac_ready[csp_pkg::N_FRAC] = out_ready;

  always_comb begin
    quo_inc = {1'b0, frac_data[csp_pkg::N_FRAC].quo} + (csp_pkg::FRAC_W + 1)'(1);
    phase_d = frac_data[csp_pkg::N_FRAC].full ? csp_pkg::FULL_SCALE
                                              : quo_inc[csp_pkg::FRAC_W:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= frac_valid[csp_pkg::N_FRAC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && frac_valid[csp_pkg::N_FRAC]) phase_q <= phase_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.phase = phase_q;

  a_phase_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (phase_q <= csp_pkg::FULL_SCALE))
    else $error("phase above full scale");

endmodule

`default_nettype wire

// ----- verif/calendar_span_phase_top_tb.sv -----
// Self-checking testbench for calendar_span_phase_top: drives time stamp requests,
// predicts each phase result and checks it. Depends on csp_pkg, csp_if and the RTL.
`timescale 1ns / 1ps

module calendar_span_phase_top_tb;

  localparam longint unsigned MINUTE_SECONDS = 60;
  localparam longint unsigned HOUR_SECONDS   = 3600;
  localparam longint unsigned DAY_SECONDS    = 86400;
  localparam longint unsigned PHASE_SCALE    = 65536;
  localparam int              IDLE_PERCENT   = 36;
  localparam int              DRAIN_CYCLES   = 100;
  localparam int              CYCLE_LIMIT    = 200000;
  localparam int              RANDOM_SETS    = 12;
  localparam int              ITEMS_PER_SET  = 42;

  typedef struct packed {
    logic [csp_pkg::SEC_W-1:0]  seconds;
    logic [csp_pkg::MIN_W-1:0]  minutes;
    logic [csp_pkg::HOUR_W-1:0] hours;
    logic [csp_pkg::DOM_W-1:0]  mday;
    logic [csp_pkg::DOW_W-1:0]  wday;
    logic [csp_pkg::DIM_W-1:0]  month_len;
  } stamp_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [csp_pkg::IDX_W-1:0] cfg_idx_i;
  logic [csp_pkg::CFG_W-1:0] cfg_wdata_i;

  csp_in_if  stamp_if ();
  csp_out_if phase_if ();

  calendar_span_phase_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (stamp_if),
    .out_o       (phase_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Shared state of driver, monitor and sequencer
  stamp_t                      pending_stamps[$];
  logic [csp_pkg::PHASE_W-1:0] expected_phases[$];
  csp_pkg::cfg_t               shadow_cfg;
  bit                          no_idle;
  int                          n_errors;
  int                          n_requests;
  int                          n_results;
  int                          n_settings;
  int                          cycle_count;

  // Phase of one time stamp under the given register settings
  function automatic logic [csp_pkg::PHASE_W-1:0] predict_phase(stamp_t st,
                                                                csp_pkg::cfg_t c);
    longint unsigned day_secs, elapsed, span_len, product, slice_no, rem, scaled;
    day_secs = st.hours * HOUR_SECONDS + st.minutes * MINUTE_SECONDS + st.seconds;
    case (c.span_mode)
      csp_pkg::MODE_HOUR: begin
        elapsed  = st.minutes * MINUTE_SECONDS + st.seconds;
        span_len = HOUR_SECONDS;
      end
      csp_pkg::MODE_DAY: begin
        elapsed  = day_secs;
        span_len = DAY_SECONDS;
      end
      csp_pkg::MODE_WEEK: begin
        elapsed  = st.wday * DAY_SECONDS + day_secs;
        span_len = 7 * DAY_SECONDS;
      end
      default: begin
        elapsed  = st.mday * DAY_SECONDS + day_secs;
        span_len = st.month_len * DAY_SECONDS;
      end
    endcase
    // a month of no days is treated as a one-second span
    if (span_len == 0) span_len = 1;
    product  = elapsed * c.slice_count;
    slice_no = product / span_len;
    rem      = product % span_len;
    if (c.wrap_enable && slice_no[0]) rem = span_len - rem;
    scaled = PHASE_SCALE * rem;
    return csp_pkg::PHASE_W'((2 * scaled + span_len) / (2 * span_len));
  endfunction

  function automatic void add_stamp(int sec, int mins, int hr, int md, int wd, int ml);
    stamp_t st;
    st.seconds   = csp_pkg::SEC_W'(sec);
    st.minutes   = csp_pkg::MIN_W'(mins);
    st.hours     = csp_pkg::HOUR_W'(hr);
    st.mday      = csp_pkg::DOM_W'(md);
    st.wday      = csp_pkg::DOW_W'(wd);
    st.month_len = csp_pkg::DIM_W'(ml);
    pending_stamps.push_back(st);
  endfunction

  // Mostly legal calendar stamps, some with every bit of every field random
  function automatic void add_random_stamp();
    if ($urandom_range(4) == 0) begin
      add_stamp($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      add_stamp($urandom_range(59), $urandom_range(59), $urandom_range(23),
                $urandom_range(30), $urandom_range(6), $urandom_range(31, 28));
    end
  endfunction

  // Returns once nothing is queued, on the wire or in flight
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_stamps.size() != 0 || stamp_if.valid || expected_phases.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_config(csp_pkg::span_mode_e mode,
                              logic [csp_pkg::CNT_W-1:0] count, logic wrap);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= csp_pkg::REG_SPAN_MODE;
    cfg_wdata_i <= csp_pkg::CFG_W'(mode);
    shadow_cfg.span_mode = mode;
    @(posedge clk_i);
    cfg_idx_i   <= csp_pkg::REG_SLICE_COUNT;
    cfg_wdata_i <= csp_pkg::CFG_W'(count);
    shadow_cfg.slice_count = count;
    @(posedge clk_i);
    cfg_idx_i   <= csp_pkg::REG_WRAP_ENABLE;
    cfg_wdata_i <= csp_pkg::CFG_W'(wrap);
    shadow_cfg.wrap_enable = wrap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_phases.size());
      $display("FAIL");
      $finish;
    end
  end

  // Request driver: predicts on acceptance, then offers the next queued stamp
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    stamp_t next_stamp, taken;
    if (!rst_ni) begin
      stamp_if.valid <= 1'b0;
    end else begin
      if (stamp_if.valid && stamp_if.ready) begin
        taken.seconds   = stamp_if.second_of_minute;
        taken.minutes   = stamp_if.minute_of_hour;
        taken.hours     = stamp_if.hour_of_day;
        taken.mday      = stamp_if.day_of_month;
        taken.wday      = stamp_if.day_of_week;
        taken.month_len = stamp_if.days_in_month;
        expected_phases.push_back(predict_phase(taken, shadow_cfg));
        n_requests++;
      end
      if (!stamp_if.valid || stamp_if.ready) begin
        if (pending_stamps.size() != 0 &&
            (no_idle || $urandom_range(99) >= IDLE_PERCENT)) begin
          next_stamp = pending_stamps.pop_front();
          stamp_if.second_of_minute <= next_stamp.seconds;
          stamp_if.minute_of_hour   <= next_stamp.minutes;
          stamp_if.hour_of_day      <= next_stamp.hours;
          stamp_if.day_of_month     <= next_stamp.mday;
          stamp_if.day_of_week      <= next_stamp.wday;
          stamp_if.days_in_month    <= next_stamp.month_len;
          stamp_if.valid            <= 1'b1;
        end else begin
          stamp_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    logic [csp_pkg::PHASE_W-1:0] want;
    if (!rst_ni) begin
      phase_if.ready <= 1'b0;
    end else begin
      if (phase_if.valid && phase_if.ready) begin
        n_results++;
        if (expected_phases.size() == 0) begin
          $display("%0t: phase result %0d with no request outstanding", $time,
                   phase_if.phase);
          n_errors++;
        end else begin
          want = expected_phases.pop_front();
          if (phase_if.phase !== want) begin
            $display("%0t: phase mismatch: expected %0d, actual %0d", $time, want,
                     phase_if.phase);
            n_errors++;
          end
        end
      end
      phase_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Sequencer
  initial begin : run_test
    csp_pkg::span_mode_e mode;
    logic [csp_pkg::CNT_W-1:0] count;
    logic wrap;
    rst_ni                    = 1'b0;
    cfg_we_i                  = 1'b0;
    cfg_idx_i                 = '0;
    cfg_wdata_i               = '0;
    stamp_if.valid            = 1'b0;
    stamp_if.second_of_minute = '0;
    stamp_if.minute_of_hour   = '0;
    stamp_if.hour_of_day      = '0;
    stamp_if.day_of_month     = '0;
    stamp_if.day_of_week      = '0;
    stamp_if.days_in_month    = '0;
    phase_if.ready            = 1'b0;
    shadow_cfg.span_mode      = csp_pkg::MODE_HOUR;
    shadow_cfg.slice_count    = csp_pkg::CNT_W'(1);
    shadow_cfg.wrap_enable    = 1'b0;
    no_idle = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset settings, zero, top of range and all-ones fields
    @(negedge clk_i);
    add_stamp(0, 0, 0, 0, 0, 28);
    add_stamp(59, 59, 23, 30, 6, 31);
    add_stamp(63, 63, 31, 31, 7, 31);

    // Day span, largest slice count, wrap on
    write_config(csp_pkg::MODE_DAY, 16'hFFFF, 1'b1);
    add_stamp(0, 0, 0, 0, 0, 30);
    add_stamp(59, 59, 23, 30, 6, 31);
    add_stamp(63, 63, 31, 31, 7, 31);
    add_stamp(30, 0, 12, 5, 3, 29);

    // Week span
    write_config(csp_pkg::MODE_WEEK, 16'd7, 1'b0);
    add_stamp(59, 59, 23, 0, 6, 30);
    add_stamp(63, 63, 31, 31, 7, 31);

    // Month span with a zero slice count
    write_config(csp_pkg::MODE_MONTH, 16'd0, 1'b0);
    add_stamp(17, 42, 9, 14, 2, 30);

    // Month span: zero-day month, day past the month's end, short and long months
    write_config(csp_pkg::MODE_MONTH, 16'd3, 1'b1);
    add_stamp(5, 10, 20, 10, 1, 0);
    add_stamp(0, 0, 0, 30, 0, 28);
    add_stamp(59, 59, 23, 27, 4, 28);
    add_stamp(0, 0, 0, 15, 0, 31);

    // Wrap in an odd slice landing exactly on a slice edge gives full scale
    write_config(csp_pkg::MODE_HOUR, 16'd2, 1'b1);
    add_stamp(0, 30, 0, 0, 0, 28);
    add_stamp(0, 45, 0, 0, 0, 28);
    add_stamp(59, 59, 0, 0, 0, 28);

    // Random stamps over a range of settings
    for (int k = 0; k < RANDOM_SETS; k++) begin
      mode = csp_pkg::span_mode_e'(k % 4);
      wrap = (k < 8) ? logic'((k / 4) % 2) : logic'($urandom_range(1));
      case (k)
        0, 5:    count = 16'hFFFF;
        1:       count = 16'd0;
        2:       count = 16'd1;
        default: count = ($urandom_range(1) == 0)
                         ? csp_pkg::CNT_W'($urandom_range(16, 1))
                         : csp_pkg::CNT_W'($urandom_range(65535));
      endcase
      write_config(mode, count, wrap);
      no_idle = (k == 6);
      for (int n = 0; n < ITEMS_PER_SET; n++) begin
        // hold the sender once until every result is back
        if (k == 3 && n == ITEMS_PER_SET / 2) wait_drained();
        add_random_stamp();
      end
    end

    wait_drained();
    no_idle = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d register settings across all span modes, %0d requests, %0d results",
             n_settings + 1, n_requests, n_results);
    $display("mismatches: %0d", n_errors);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- calendar_span_phase_top.f -----
hdl/csp_pkg.sv
hdl/csp_if.sv
hdl/csp_front.sv
hdl/csp_div_cell.sv
hdl/csp_wrap.sv
hdl/calendar_span_phase_top.sv
verif/calendar_span_phase_top_tb.sv
